/* hdl/qenc_pkg.sv */
// ----------------------------------------------------------------------------
// qenc_pkg
// Shared codes, register indexes and helper functions for the three-channel
// quadrature encoder decoder.
// ----------------------------------------------------------------------------
package qenc_pkg;

  // Number of encoder channels
  localparam int unsigned NumEnc = 3;

  // Operation codes carried by the mode field
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_TAKE   = 2'd1;
  localparam logic [1:0] MODE_MARK   = 2'd2;
  localparam logic [1:0] MODE_INIT   = 2'd3;

  // Channel index that selects no channel
  localparam logic [1:0] IDX_NONE = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_SCROLL_TRANS = 3'd0;
  localparam logic [2:0] REG_TEMPO_TRANS  = 3'd1;
  localparam logic [2:0] REG_MID_IVL      = 3'd2;
  localparam logic [2:0] REG_FAST_IVL     = 3'd3;
  localparam logic [2:0] REG_VFAST_IVL    = 3'd4;
  localparam logic [2:0] REG_MID_STEP     = 3'd5;
  localparam logic [2:0] REG_FAST_STEP    = 3'd6;
  localparam logic [2:0] REG_VFAST_STEP   = 3'd7;

  // Register reset values
  localparam logic [6:0]  RST_SCROLL_TRANS = 7'd4;
  localparam logic [6:0]  RST_TEMPO_TRANS  = 7'd4;
  localparam logic [15:0] RST_MID_IVL      = 16'd60;
  localparam logic [15:0] RST_FAST_IVL     = 16'd35;
  localparam logic [15:0] RST_VFAST_IVL    = 16'd20;
  localparam logic [6:0]  RST_MID_STEP     = 7'd2;
  localparam logic [6:0]  RST_FAST_STEP    = 7'd4;
  localparam logic [6:0]  RST_VFAST_STEP   = 7'd8;

  // Per-channel pin pair, a in bit 1 and b in bit 0
  typedef logic [1:0] pins_t;

  // Gray transition delta: 00->01->11->10 counts up, reverse counts down,
  // a two-bit jump or no change counts zero
  function automatic logic signed [1:0] gray_delta(input pins_t prev, input pins_t cur);
    logic signed [1:0] d;
    case ({prev, cur})
      4'b0001, 4'b0111, 4'b1110, 4'b1000: d = 2'sd1;
      4'b0010, 4'b1011, 4'b0100, 4'b1101: d = -2'sd1;
      default:                            d = 2'sd0;
    endcase
    return d;
  endfunction

  // Clamp a 10-bit signed value to the signed 8-bit range
  function automatic logic signed [7:0] sat8(input logic signed [9:0] v);
    logic signed [7:0] r;
    if (v > 10'sd127) begin
      r = 8'sd127;
    end else if (v < -10'sd128) begin
      r = -8'sd128;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

/* hdl/quadrature_encoder_accel_decoder.sv */
// ----------------------------------------------------------------------------
// quadrature_encoder_accel_decoder
// Three-channel quadrature decoder with interval-based step acceleration on
// the third channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per command:
//   sample pins, take motion, mark activity or initialize. Only a take
//   produces a word on the output channel (out_valid_o / out_stall_i) with
//   the channel's activity flag and saturated motion delta.
//   Configuration writes use cfg_valid_i / cfg_ready_o; ready is always high
//   and every write is accepted. Write only while the block is idle.
//   A word accepted into the input register executes from there; a take
//   result is loaded into the output register and presented on the output.
//   Throughput: one word per cycle while in_stall_o is low. The input register
//   and the output register form a two-stage pipe, so samples, marks and inits
//   keep flowing while a result waits.
//   When the receiver stalls a pending result, the next take is held in the
//   input register and in_stall_o stays high until the result is accepted.
//   Reset clears all channel state and restores the register defaults.
// ----------------------------------------------------------------------------
module quadrature_encoder_accel_decoder
  import qenc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic               enc1_a_i,
  input  logic               enc1_b_i,
  input  logic               enc2_a_i,
  input  logic               enc2_b_i,
  input  logic               enc3_a_i,
  input  logic               enc3_b_i,
  input  logic [31:0]        now_ms_i,
  input  logic [1:0]         encoder_index_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               activity_o,
  output logic signed [7:0]  motion_delta_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [6:0]  scroll_trans_q, tempo_trans_q;
  logic [15:0] mid_ivl_q, fast_ivl_q, vfast_ivl_q;
  logic [6:0]  mid_step_q, fast_step_q, vfast_step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_trans_q <= RST_SCROLL_TRANS;
      tempo_trans_q  <= RST_TEMPO_TRANS;
      mid_ivl_q      <= RST_MID_IVL;
      fast_ivl_q     <= RST_FAST_IVL;
      vfast_ivl_q    <= RST_VFAST_IVL;
      mid_step_q     <= RST_MID_STEP;
      fast_step_q    <= RST_FAST_STEP;
      vfast_step_q   <= RST_VFAST_STEP;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SCROLL_TRANS: scroll_trans_q <= cfg_data_i[6:0];
        REG_TEMPO_TRANS:  tempo_trans_q  <= cfg_data_i[6:0];
        REG_MID_IVL:      mid_ivl_q      <= cfg_data_i;
        REG_FAST_IVL:     fast_ivl_q     <= cfg_data_i;
        REG_VFAST_IVL:    vfast_ivl_q    <= cfg_data_i;
        REG_MID_STEP:     mid_step_q     <= cfg_data_i[6:0];
        REG_FAST_STEP:    fast_step_q    <= cfg_data_i[6:0];
        REG_VFAST_STEP:   vfast_step_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  s1_mode_q;
  pins_t       s1_pins_q [NumEnc];
  logic [31:0] s1_now_q;
  logic [1:0]  s1_idx_q;
  logic        in_fire, s1_fire, s1_take, s1_idx_ok;

  // an executing take needs a free (or draining) output register
  assign s1_take    = (s1_mode_q == MODE_TAKE);
  assign s1_idx_ok  = (s1_idx_q != IDX_NONE);
  assign s1_fire    = s1_valid_q && (!s1_take || !out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mode_q    <= mode_i;
      s1_pins_q[0] <= {enc1_a_i, enc1_b_i};
      s1_pins_q[1] <= {enc2_a_i, enc2_b_i};
      s1_pins_q[2] <= {enc3_a_i, enc3_b_i};
      s1_now_q     <= now_ms_i;
      s1_idx_q     <= encoder_index_i;
    end
  end

  // --------------------------------------------------------------------------
  // Channel state
  // --------------------------------------------------------------------------
  pins_t             prev_q [NumEnc], prev_d [NumEnc];
  logic signed [7:0] sum_q  [NumEnc], sum_d  [NumEnc];
  logic signed [7:0] pend_q [NumEnc], pend_d [NumEnc];
  logic [NumEnc-1:0] act_q, act_d;
  logic [31:0]       last_q, last_d;

  // Tempo magnitude for channel three from the interval since its last step
  logic [31:0] interval;
  logic [6:0]  tempo_mag;

  always_comb begin
    interval = (last_q == 32'd0) ? 32'hFFFF_FFFF : (s1_now_q - last_q);
    if (interval <= {16'd0, vfast_ivl_q}) begin
      tempo_mag = vfast_step_q;
    end else if (interval <= {16'd0, fast_ivl_q}) begin
      tempo_mag = fast_step_q;
    end else if (interval <= {16'd0, mid_ivl_q}) begin
      tempo_mag = mid_step_q;
    end else begin
      tempo_mag = 7'd1;
    end
  end

  // Per-channel sample update, all three channels side by side
  logic                    chg      [NumEnc];
  logic signed [1:0]       dlt      [NumEnc];
  logic signed [7:0]       sum_upd  [NumEnc];
  logic signed [9:0]       thr      [NumEnc];
  logic                    step_pos [NumEnc];
  logic                    step_neg [NumEnc];
  logic signed [9:0]       step_amt [NumEnc];
  logic signed [7:0]       pend_upd [NumEnc];

  always_comb begin
    for (int e = 0; e < NumEnc; e++) begin
      chg[e]     = (s1_pins_q[e] != prev_q[e]);
      dlt[e]     = gray_delta(prev_q[e], s1_pins_q[e]);
      sum_upd[e] = sat8({{2{sum_q[e][7]}}, sum_q[e]} + {{8{dlt[e][1]}}, dlt[e]});
      thr[e]     = (e == NumEnc - 1) ? $signed({3'b000, tempo_trans_q})
                                     : $signed({3'b000, scroll_trans_q});
      step_pos[e] = ($signed({{2{sum_upd[e][7]}}, sum_upd[e]}) >= thr[e]);
      step_neg[e] = ($signed({{2{sum_upd[e][7]}}, sum_upd[e]}) <= -thr[e]);
      if (e == NumEnc - 1) begin
        step_amt[e] = $signed({3'b000, tempo_mag});
      end else begin
        step_amt[e] = 10'sd1;
      end
      if (!step_pos[e]) begin
        step_amt[e] = -step_amt[e];
      end
      pend_upd[e] = sat8({{2{pend_q[e][7]}}, pend_q[e]} + step_amt[e]);
    end
  end

  // Command execution
  always_comb begin
    for (int e = 0; e < NumEnc; e++) begin
      prev_d[e] = prev_q[e];
      sum_d[e]  = sum_q[e];
      pend_d[e] = pend_q[e];
    end
    act_d  = act_q;
    last_d = last_q;
    if (s1_fire) begin
      case (s1_mode_q)
        MODE_SAMPLE: begin
          for (int e = 0; e < NumEnc; e++) begin
            if (chg[e]) begin
              act_d[e]  = 1'b1;
              prev_d[e] = s1_pins_q[e];
              if (step_pos[e] || step_neg[e]) begin
                sum_d[e]  = 8'sd0;
                pend_d[e] = pend_upd[e];
                if (e == NumEnc - 1) begin
                  last_d = s1_now_q;
                end
              end else begin
                sum_d[e] = sum_upd[e];
              end
            end
          end
        end
        MODE_TAKE: begin
          if (s1_idx_ok) begin
            act_d[s1_idx_q]  = 1'b0;
            pend_d[s1_idx_q] = 8'sd0;
          end
        end
        MODE_MARK: begin
          if (s1_idx_ok) begin
            act_d[s1_idx_q] = 1'b1;
          end
        end
        MODE_INIT: begin
          for (int e = 0; e < NumEnc; e++) begin
            prev_d[e] = s1_pins_q[e];
            sum_d[e]  = 8'sd0;
            pend_d[e] = 8'sd0;
          end
          act_d  = '0;
          last_d = 32'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < NumEnc; e++) begin
        prev_q[e] <= '0;
        sum_q[e]  <= '0;
        pend_q[e] <= '0;
      end
      act_q  <= '0;
      last_q <= '0;
    end else begin
      for (int e = 0; e < NumEnc; e++) begin
        prev_q[e] <= prev_d[e];
        sum_q[e]  <= sum_d[e];
        pend_q[e] <= pend_d[e];
      end
      act_q  <= act_d;
      last_q <= last_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic              out_valid_q, out_valid_d;
  logic              out_act_q;
  logic signed [7:0] out_delta_q;
  logic              out_load;

  assign out_load = s1_fire && s1_take;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_act_q   <= s1_idx_ok ? act_q[s1_idx_q] : 1'b0;
      out_delta_q <= s1_idx_ok ? pend_q[s1_idx_q] : 8'sd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign activity_o     = out_act_q;
  assign motion_delta_o = out_delta_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // stall back-pressure only arises from a take blocked by a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_take && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked take");

  // every executed take presents a result next cycle
  a_take_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("take executed but no result presented");

  // initialize clears flags, deltas and the step time
  a_init_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_mode_q == MODE_INIT) |=>
      (act_q == '0 && last_q == 32'd0 && pend_q[0] == 8'sd0 &&
       pend_q[1] == 8'sd0 && pend_q[2] == 8'sd0))
    else $error("initialize left channel state behind");

  // the step time moves only on an executed command
  a_last_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(last_q))
    else $error("step time changed without a command");

  // a take of a valid channel clears its activity flag
  a_take_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && s1_idx_ok) |=> !act_q[$past(s1_idx_q)])
    else $error("take did not clear the activity flag");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-channel quadrature decoder. Drives command
// words with random bursts and gaps, stalls the result side on a shifting
// pattern, predicts every take result in-bench and compares field by field.
// ----------------------------------------------------------------------------
module tb;
  import qenc_pkg::*;

  // Channel that carries the interval-scaled step
  localparam int TempoChan = 2;

  typedef struct packed {
    logic [1:0]  mode;
    pins_t [2:0] pins;
    logic [31:0] now;
    logic [1:0]  idx;
  } cmd_word_t;

  typedef struct packed {
    logic              act;
    logic signed [7:0] delta;
  } motion_report_t;

  // DUT signals
  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_valid_i     = 1'b0;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i     = '0;
  logic [15:0]       cfg_data_i      = '0;
  logic              in_valid_i      = 1'b0;
  logic              in_stall_o;
  logic [1:0]        mode_i          = MODE_SAMPLE;
  logic              enc1_a_i        = 1'b0;
  logic              enc1_b_i        = 1'b0;
  logic              enc2_a_i        = 1'b0;
  logic              enc2_b_i        = 1'b0;
  logic              enc3_a_i        = 1'b0;
  logic              enc3_b_i        = 1'b0;
  logic [31:0]       now_ms_i        = '0;
  logic [1:0]        encoder_index_i = '0;
  logic              out_valid_o;
  logic              out_stall_i     = 1'b0;
  logic              activity_o;
  logic signed [7:0] motion_delta_o;

  quadrature_encoder_accel_decoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .enc1_a_i        (enc1_a_i),
    .enc1_b_i        (enc1_b_i),
    .enc2_a_i        (enc2_a_i),
    .enc2_b_i        (enc2_b_i),
    .enc3_a_i        (enc3_a_i),
    .enc3_b_i        (enc3_b_i),
    .now_ms_i        (now_ms_i),
    .encoder_index_i (encoder_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .activity_o      (activity_o),
    .motion_delta_o  (motion_delta_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Decoder state mirror and register copies
  // --------------------------------------------------------------------------
  pins_t       enc_prev    [3] = '{default: 2'b00};
  int          enc_sum     [3] = '{default: 0};
  int          enc_pending [3] = '{default: 0};
  bit          enc_active  [3] = '{default: 1'b0};
  logic [31:0] tempo_last_ms   = '0;

  int          cfg_scroll_t    = RST_SCROLL_TRANS;
  int          cfg_tempo_t     = RST_TEMPO_TRANS;
  logic [31:0] cfg_mid_ivl     = RST_MID_IVL;
  logic [31:0] cfg_fast_ivl    = RST_FAST_IVL;
  logic [31:0] cfg_vfast_ivl   = RST_VFAST_IVL;
  int          cfg_mid_step    = RST_MID_STEP;
  int          cfg_fast_step   = RST_FAST_STEP;
  int          cfg_vfast_step  = RST_VFAST_STEP;

  motion_report_t take_reports[$];
  motion_report_t want;
  int             err_count = 0;

  // Stimulus-side bookkeeping
  pins_t [2:0] stim_pins   = '0;
  logic [31:0] stim_now    = '0;
  int          walk_dir[3] = '{1, -1, 1};
  bit          gaps_on     = 1'b1;
  bit          offering    = 1'b0;
  int          burst_left  = 0;

  // Receiver hold-off requests
  int          hold_reqs   = 0;
  int          hold_seen   = 0;
  int          hold_left   = 0;
  logic [15:0] stall_bits  = '0;
  int          stall_pos   = 0;

  function automatic int clamp_s8(input int v);
    if (v > 127) return 127;
    if (v < -128) return -128;
    return v;
  endfunction

  // Position along the Gray cycle 00, 01, 11, 10
  function automatic int gray_pos(input pins_t p);
    case (p)
      2'b00:   return 0;
      2'b01:   return 1;
      2'b11:   return 2;
      default: return 3;
    endcase
  endfunction

  function automatic pins_t gray_at(input int pos);
    case (pos & 3)
      0:       return 2'b00;
      1:       return 2'b01;
      2:       return 2'b11;
      default: return 2'b10;
    endcase
  endfunction

  // +1 one step forward, -1 one step back, 0 for a jump of two
  function automatic int gray_step(input pins_t prev, input pins_t cur);
    int d;
    d = (gray_pos(cur) - gray_pos(prev)) & 3;
    if (d == 1) return 1;
    if (d == 3) return -1;
    return 0;
  endfunction

  // One channel's response to a pin sample
  function automatic void advance_channel(input int e, input pins_t cur, input int t,
                                          input logic [31:0] now);
    int          dir;
    int          mag;
    logic [31:0] ivl;
    if (cur == enc_prev[e]) return;
    enc_active[e] = 1'b1;
    enc_sum[e]    = clamp_s8(enc_sum[e] + gray_step(enc_prev[e], cur));
    enc_prev[e]   = cur;
    dir = 0;
    if (enc_sum[e] >= t) dir = 1;
    else if (enc_sum[e] <= -t) dir = -1;
    if (dir == 0) return;
    enc_sum[e] = 0;
    mag = 1;
    if (e == TempoChan) begin
      // zero time stamp means no step seen yet: treat as slowest
      ivl = (tempo_last_ms == 32'd0) ? 32'hFFFF_FFFF : now - tempo_last_ms;
      if (ivl <= cfg_vfast_ivl) mag = cfg_vfast_step;
      else if (ivl <= cfg_fast_ivl) mag = cfg_fast_step;
      else if (ivl <= cfg_mid_ivl) mag = cfg_mid_step;
      tempo_last_ms = now;
    end
    enc_pending[e] = clamp_s8(enc_pending[e] + dir * mag);
  endfunction

  // Update the mirror for one accepted word; a take queues its report
  function automatic void apply_command(input cmd_word_t w);
    motion_report_t r;
    case (w.mode)
      MODE_SAMPLE: begin
        advance_channel(0, w.pins[0], cfg_scroll_t, w.now);
        advance_channel(1, w.pins[1], cfg_scroll_t, w.now);
        advance_channel(TempoChan, w.pins[TempoChan], cfg_tempo_t, w.now);
      end
      MODE_TAKE: begin
        r = '0;
        if (w.idx != IDX_NONE) begin
          r.act               = enc_active[w.idx];
          r.delta             = 8'(enc_pending[w.idx]);
          enc_active[w.idx]  = 1'b0;
          enc_pending[w.idx] = 0;
        end
        take_reports.push_back(r);
      end
      MODE_MARK: begin
        if (w.idx != IDX_NONE) enc_active[w.idx] = 1'b1;
      end
      default: begin
        for (int e = 0; e < 3; e++) begin
          enc_prev[e]    = w.pins[e];
          enc_sum[e]     = 0;
          enc_pending[e] = 0;
          enc_active[e]  = 1'b0;
        end
        tempo_last_ms = '0;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall pattern, long hold-offs, and the checker
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = 300;
    end
    // new 16-bit stall pattern, sometimes empty, sometimes dense
    if (stall_pos == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: stall_bits = '0;
        3:       stall_bits = 16'($urandom | $urandom);
        default: stall_bits = 16'($urandom);
      endcase
    end
    out_stall_i <= (hold_left > 0) || stall_bits[stall_pos];
    if (hold_left > 0) hold_left--;
    stall_pos = (stall_pos + 1) % 16;
  end

  // Sampled mid-cycle: valid and not stalled means taken at the next edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (take_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected word act=%0b delta=%0d",
                                  activity_o, motion_delta_o));
      end else begin
        want = take_reports.pop_front();
        if (activity_o !== want.act)
          report_mismatch($sformatf("activity %0b, predicted %0b", activity_o, want.act));
        if (motion_delta_o !== want.delta)
          report_mismatch($sformatf("motion_delta %0d, predicted %0d",
                                    motion_delta_o, want.delta));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  task automatic lower_valid();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_word(input cmd_word_t w);
    bit taken;
    // burst boundary: drop valid for a random gap
    if (gaps_on && burst_left <= 0) begin
      lower_valid();
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(8, 30)) @(posedge clk_i);
      else repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i      <= 1'b1;
    offering = 1'b1;
    mode_i          <= w.mode;
    enc1_a_i        <= w.pins[0][1];
    enc1_b_i        <= w.pins[0][0];
    enc2_a_i        <= w.pins[1][1];
    enc2_b_i        <= w.pins[1][0];
    enc3_a_i        <= w.pins[2][1];
    enc3_b_i        <= w.pins[2][0];
    now_ms_i        <= w.now;
    encoder_index_i <= w.idx;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    apply_command(w);
    if (w.mode == MODE_SAMPLE) begin
      stim_pins = w.pins;
      stim_now  = w.now;
    end else if (w.mode == MODE_INIT) begin
      stim_pins = w.pins;
    end
    burst_left--;
  endtask

  task automatic send_cmd(input logic [1:0] mode, input pins_t p1, input pins_t p2,
                          input pins_t p3, input logic [31:0] now, input logic [1:0] idx);
    cmd_word_t w;
    w.mode = mode;
    w.pins = {p3, p2, p1};
    w.now  = now;
    w.idx  = idx;
    send_word(w);
  endtask

  // Wait out every pending report plus the pipe latency
  task automatic drain_pipe();
    int waited;
    waited = 0;
    lower_valid();
    while (take_reports.size() > 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (take_reports.size() > 0) begin
      report_mismatch($sformatf("%0d take results never arrived", take_reports.size()));
      take_reports.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    case (idx)
      REG_SCROLL_TRANS: cfg_scroll_t   = data[6:0];
      REG_TEMPO_TRANS:  cfg_tempo_t    = data[6:0];
      REG_MID_IVL:      cfg_mid_ivl    = {16'd0, data};
      REG_FAST_IVL:     cfg_fast_ivl   = {16'd0, data};
      REG_VFAST_IVL:    cfg_vfast_ivl  = {16'd0, data};
      REG_MID_STEP:     cfg_mid_step   = data[6:0];
      REG_FAST_STEP:    cfg_fast_step  = data[6:0];
      default:          cfg_vfast_step = data[6:0];
    endcase
  endtask

  // Full register set, written only with the pipe empty
  task automatic program_regs(input int scroll_t, input int tempo_t, input int mid_ivl,
                              input int fast_ivl, input int vfast_ivl, input int mid_step,
                              input int fast_step, input int vfast_step);
    drain_pipe();
    write_reg(REG_SCROLL_TRANS, 16'(scroll_t));
    write_reg(REG_TEMPO_TRANS,  16'(tempo_t));
    write_reg(REG_MID_IVL,      16'(mid_ivl));
    write_reg(REG_FAST_IVL,     16'(fast_ivl));
    write_reg(REG_VFAST_IVL,    16'(vfast_ivl));
    write_reg(REG_MID_STEP,     16'(mid_step));
    write_reg(REG_FAST_STEP,    16'(fast_step));
    write_reg(REG_VFAST_STEP,   16'(vfast_step));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Random word generation
  // --------------------------------------------------------------------------
  function automatic logic [1:0] pick_channel();
    return ($urandom_range(0, 9) == 0) ? IDX_NONE : 2'($urandom_range(0, 2));
  endfunction

  // Mostly a directed walk along the Gray cycle, with back-steps, jumps, noise
  function automatic pins_t next_pins(input int e);
    int r;
    int pos;
    r   = $urandom_range(0, 99);
    pos = gray_pos(stim_pins[e]);
    if (r < 3) walk_dir[e] = -walk_dir[e];
    if (r < 68) return gray_at(pos + walk_dir[e]);
    if (r < 78) return gray_at(pos - walk_dir[e]);
    if (r < 88) return stim_pins[e];
    if (r < 94) return gray_at(pos + 2);
    return 2'($urandom);
  endfunction

  // Tick count: mostly small advances, now and then big jumps and the wrap
  function automatic logic [31:0] next_now();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return stim_now + $urandom_range(0, 25);
    if (r < 85) return stim_now + $urandom_range(20, 90);
    if (r < 93) return stim_now + $urandom_range(0, 3000);
    if (r < 96) return $urandom;
    if (r < 98) return 32'hFFFF_FFFF - $urandom_range(0, 40);
    return '0;
  endfunction

  task automatic random_word(input int take_pct);
    cmd_word_t w;
    int        r;
    w.mode = MODE_SAMPLE;
    w.pins = 6'($urandom);
    w.now  = $urandom;
    w.idx  = 2'($urandom);
    r = $urandom_range(0, 99);
    if (r < take_pct) begin
      w.mode = MODE_TAKE;
      w.idx  = pick_channel();
    end else if (r < take_pct + 3) begin
      w.mode = MODE_MARK;
      w.idx  = pick_channel();
    end else if (r < take_pct + 4) begin
      w.mode = MODE_INIT;
    end else begin
      w.now = next_now();
      for (int e = 0; e < 3; e++) w.pins[e] = next_pins(e);
    end
    send_word(w);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Gray counting both ways, jump, take, mark, invalid channel (reset regs)
  task automatic test_gray_and_take();
    send_cmd(MODE_INIT,   2'b00, 2'b00, 2'b00, 32'd0, 2'd0);
    send_cmd(MODE_SAMPLE, 2'b01, 2'b10, 2'b11, 32'd1, 2'd0);
    send_cmd(MODE_SAMPLE, 2'b11, 2'b11, 2'b11, 32'd2, 2'd0);
    send_cmd(MODE_SAMPLE, 2'b10, 2'b01, 2'b11, 32'd3, 2'd0);
    send_cmd(MODE_SAMPLE, 2'b00, 2'b00, 2'b11, 32'd4, 2'd0);
    send_cmd(MODE_TAKE,   2'b11, 2'b11, 2'b11, 32'hFFFF_FFFF, 2'd0);
    send_cmd(MODE_TAKE,   2'b11, 2'b11, 2'b11, 32'hFFFF_FFFF, 2'd1);
    send_cmd(MODE_TAKE,   2'b00, 2'b00, 2'b00, 32'd0, 2'd2);
    send_cmd(MODE_TAKE,   2'b00, 2'b00, 2'b00, 32'd0, IDX_NONE);
    send_cmd(MODE_MARK,   2'b00, 2'b00, 2'b00, 32'd0, 2'd1);
    send_cmd(MODE_MARK,   2'b00, 2'b00, 2'b00, 32'd0, IDX_NONE);
    send_cmd(MODE_TAKE,   2'b00, 2'b00, 2'b00, 32'd0, 2'd1);
  endtask

  // Every speed band, first step, interval wrap, a step at tick zero, init
  task automatic test_acceleration();
    program_regs(4, 1, 60, 35, 20, 2, 4, 8);
    send_cmd(MODE_INIT,   2'b00, 2'b00, 2'b00, 32'd0, 2'd0);
    send_cmd(MODE_SAMPLE, 2'b00, 2'b00, 2'b01, 32'd1000, 2'd0);
    send_cmd(MODE_SAMPLE, 2'b00, 2'b00, 2'b11, 32'd1020, 2'd0);
    send_cmd(MODE_SAMPLE, 2'b00, 2'b00, 2'b10, 32'd1055, 2'd0);
    send_cmd(MODE_SAMPLE, 2'b00, 2'b00, 2'b00, 32'd1115, 2'd0);
    send_cmd(MODE_SAMPLE, 2'b00, 2'b00, 2'b01, 32'd1176, 2'd0);
    send_cmd(MODE_TAKE,   2'b00, 2'b00, 2'b00, 32'd0, 2'd2);
    send_cmd(MODE_SAMPLE, 2'b00, 2'b00, 2'b11, 32'hFFFF_FFF0, 2'd0);
    send_cmd(MODE_SAMPLE, 2'b00, 2'b00, 2'b10, 32'h0000_0010, 2'd0);
    send_cmd(MODE_SAMPLE, 2'b00, 2'b00, 2'b00, 32'd0, 2'd0);
    send_cmd(MODE_SAMPLE, 2'b00, 2'b00, 2'b10, 32'd5, 2'd0);
    send_cmd(MODE_TAKE,   2'b00, 2'b00, 2'b00, 32'd0, 2'd2);
    send_cmd(MODE_INIT,   2'b11, 2'b11, 2'b11, 32'd77, 2'd0);
    send_cmd(MODE_TAKE,   2'b00, 2'b00, 2'b00, 32'd0, 2'd2);
  endtask

  // Long receiver hold-off while takes keep coming with no gaps
  task automatic test_backpressure();
    hold_reqs++;
    gaps_on = 1'b0;
    repeat (40) random_word(60);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_defaults();
    program_regs(RST_SCROLL_TRANS, RST_TEMPO_TRANS, RST_MID_IVL, RST_FAST_IVL,
                 RST_VFAST_IVL, RST_MID_STEP, RST_FAST_STEP, RST_VFAST_STEP);
    repeat (450) random_word(15);
  endtask

  // One transition per step, largest steps, rare takes to reach saturation
  task automatic test_random_extremes();
    program_regs(1, 1, 65535, 65535, 0, 1, 127, 127);
    repeat (450) random_word(1);
  endtask

  // Longest count per step on the scroll channels, zero count on the tempo one
  task automatic test_random_wide_counts();
    program_regs(127, 0, 65535, 0, 0, 3, 1, 127);
    repeat (450) random_word(8);
  endtask

  task automatic test_random_settings();
    int vf;
    int fs;
    repeat (3) begin
      vf = $urandom_range(0, 40);
      fs = vf + $urandom_range(0, 40);
      program_regs($urandom_range(1, 12), $urandom_range(1, 8), fs + $urandom_range(0, 60),
                   fs, vf, $urandom_range(1, 127), $urandom_range(1, 127),
                   $urandom_range(1, 127));
      repeat (150) random_word($urandom_range(5, 25));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_gray_and_take();
    test_acceleration();
    test_backpressure();
    test_random_defaults();
    test_random_extremes();
    test_random_wide_counts();
    test_random_settings();
    drain_pipe();
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
